// File: hdl/aed_pkg.sv
// Shared types, widths, register codes and the arctangent table of the deadband block.
package aed_pkg;

	// CORDIC step count default and the longest table that is kept
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_LEN         = 24;
	localparam int STEP_W           = 5;

	// Field and datapath widths
	localparam int COMP_W  = 16;
	localparam int NORM_W  = 16;
	localparam int SUM_W   = 32;
	localparam int REM_W   = 17;
	localparam int XY_W    = 21;
	localparam int Z_W     = 20;
	localparam int THR_W   = 16;
	localparam int CIDX_W  = 8;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] REG_OUTER_ATT  = 8'd0;
	localparam logic [CIDX_W-1:0] REG_INNER_ATT  = 8'd1;
	localparam logic [CIDX_W-1:0] REG_OUTER_RATE = 8'd2;
	localparam logic [CIDX_W-1:0] REG_INNER_RATE = 8'd3;

	typedef logic signed [COMP_W-1:0] comp_t;
	typedef logic [NORM_W-1:0]        norm_t;
	typedef logic [THR_W-1:0]         thr_t;

	typedef struct packed {
		comp_t x;
		comp_t y;
		comp_t z;
	} vec3_t;

	// Start strobe from the sequencer to an iterative unit
	typedef struct packed {
		logic start;
	} unit_cmd_t;

	// atan(2^-i) in radians, 16 fraction bits, rounded
	function automatic logic [15:0] atan_q16(input logic [STEP_W-1:0] i);
		logic [15:0] v;
		case (i)
			5'd0:    v = 16'd51472;
			5'd1:    v = 16'd30386;
			5'd2:    v = 16'd16055;
			5'd3:    v = 16'd8150;
			5'd4:    v = 16'd4091;
			5'd5:    v = 16'd2047;
			5'd6:    v = 16'd1024;
			5'd7:    v = 16'd512;
			5'd8:    v = 16'd256;
			5'd9:    v = 16'd128;
			5'd10:   v = 16'd64;
			5'd11:   v = 16'd32;
			5'd12:   v = 16'd16;
			5'd13:   v = 16'd8;
			5'd14:   v = 16'd4;
			5'd15:   v = 16'd2;
			5'd16:   v = 16'd1;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

// File: hdl/aed_if.sv
// Valid/ready channel interfaces for the input word and the result word.
interface aed_in_if;
	logic                 valid;
	logic                 ready;
	logic signed [15:0]   sigma_x;
	logic signed [15:0]   sigma_y;
	logic signed [15:0]   sigma_z;
	logic signed [15:0]   omega_x;
	logic signed [15:0]   omega_y;
	logic signed [15:0]   omega_z;

	modport source (output valid, sigma_x, sigma_y, sigma_z, omega_x, omega_y, omega_z,
		input ready);
	modport sink (input valid, sigma_x, sigma_y, sigma_z, omega_x, omega_y, omega_z,
		output ready);
endinterface

interface aed_out_if;
	logic                 valid;
	logic                 ready;
	logic signed [15:0]   out_sigma_x;
	logic signed [15:0]   out_sigma_y;
	logic signed [15:0]   out_sigma_z;
	logic signed [15:0]   out_omega_x;
	logic signed [15:0]   out_omega_y;
	logic signed [15:0]   out_omega_z;
	logic                 control_off;

	modport source (output valid, out_sigma_x, out_sigma_y, out_sigma_z, out_omega_x,
		out_omega_y, out_omega_z, control_off, input ready);
	modport sink (input valid, out_sigma_x, out_sigma_y, out_sigma_z, out_omega_x,
		out_omega_y, out_omega_z, control_off, output ready);
endinterface

// File: hdl/aed_norm.sv
// Euclidean norm of a three-component vector: shared squarer, then a bit-per-cycle square root.
module aed_norm (
	input  logic              clk,
	input  logic              arst_n,
	input  aed_pkg::unit_cmd_t cmd,
	input  aed_pkg::vec3_t    vec,
	output logic              done,
	output aed_pkg::norm_t    root
);
	import aed_pkg::*;

	localparam int SQRT_STEPS = SUM_W / 2;

	logic                 busy_q;
	logic                 sqrt_q;
	logic [STEP_W-1:0]    cnt_q;
	vec3_t                vec_q;
	logic [SUM_W-1:0]     prod_s1;
	logic                 prod_vld_s1;
	logic [SUM_W-1:0]     acc_q;
	logic [REM_W-1:0]     rem_q;
	norm_t                root_q;
	logic                 done_q;

	comp_t                opnd;
	logic signed [SUM_W-1:0] sq;
	logic [REM_W+1:0]     cur;
	logic [REM_W+1:0]     trial;
	logic                 take;

	// Pick the component to square this cycle
	always_comb begin
		case (cnt_q[1:0])
			2'd0:    opnd = vec_q.x;
			2'd1:    opnd = vec_q.y;
			default: opnd = vec_q.z;
		endcase
		sq    = opnd * opnd;
		cur   = {rem_q, acc_q[SUM_W-1 -: 2]};
		trial = {1'b0, root_q, 2'b01};
		take  = (cur >= trial);
	end

	// Square and accumulate, then take the root one bit at a time, two radicand bits per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			sqrt_q      <= 1'b0;
			cnt_q       <= '0;
			prod_vld_s1 <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q      <= 1'b0;
			prod_vld_s1 <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				sqrt_q <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q && !sqrt_q) begin
				prod_vld_s1 <= (cnt_q < STEP_W'(3));
				if (cnt_q == STEP_W'(3)) begin
					sqrt_q <= 1'b1;
					cnt_q  <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else if (busy_q) begin
				if (cnt_q == STEP_W'(SQRT_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			vec_q  <= vec;
			acc_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q && !sqrt_q) begin
			prod_s1 <= SUM_W'(unsigned'(sq));
			if (prod_vld_s1)
				acc_q <= acc_q + prod_s1;
		end else if (busy_q) begin
			acc_q <= {acc_q[SUM_W-3:0], 2'b00};
			if (take) begin
				rem_q  <= REM_W'(cur - trial);
				root_q <= {root_q[NORM_W-2:0], 1'b1};
			end else begin
				rem_q  <= REM_W'(cur);
				root_q <= {root_q[NORM_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: hdl/aed_cordic.sv
// Vectoring CORDIC giving 4*atan of a norm, one micro-rotation per cycle.
module aed_cordic #(
	parameter int CORDIC_STEPS = aed_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  aed_pkg::unit_cmd_t cmd,
	input  aed_pkg::norm_t     n,
	output logic               done,
	output aed_pkg::thr_t      angle
);
	import aed_pkg::*;

	localparam int ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

	logic                    busy_q;
	logic                    done_q;
	logic [STEP_W-1:0]       i_q;
	logic signed [XY_W-1:0]  x_q;
	logic signed [XY_W-1:0]  y_q;
	logic signed [Z_W-1:0]   z_q;

	logic signed [XY_W-1:0]  xs;
	logic signed [XY_W-1:0]  ys;
	logic signed [Z_W-1:0]   at;
	logic [Z_W-2:0]          zh;

	// Shifted operands and table angle for this step
	always_comb begin
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = signed'(Z_W'(atan_q16(i_q)));
	end

	// Negative residual reads as zero; halve to 13 fraction bits and clamp
	always_comb begin
		zh = z_q[Z_W-1] ? '0 : z_q[Z_W-1:1];
		if (zh > (Z_W-1)'(16'hFFFF))
			angle = 16'hFFFF;
		else
			angle = zh[THR_W-1:0];
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == STEP_W'(ITERS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				i_q <= i_q + 1'b1;
			end
		end
	end

	// Rotate towards the x axis
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q <= XY_W'(32'sd65536);
			y_q <= signed'(XY_W'({n, 2'b00}));
			z_q <= '0;
		end else if (busy_q) begin
			if (!y_q[XY_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	assign done = done_q;

endmodule

// File: hdl/attitude_error_deadband.sv
// Top level: sequencer, threshold registers, hysteresis state and result register.
// One word at a time. The input is ready only while the sequencer is idle, and each word
// passes in turn through the shared units: a norm pass (a start, squaring and accumulation,
// sixteen root steps), one CORDIC pass (a step count above 24 runs 24 rotations), a second
// norm pass, then sequencing and result loading. The input is ready again as soon as the
// result is in the output register, so the next word is taken while the result waits; it
// is completed only once that result has been taken, and it stalls for as long as the
// result stays untaken. Thresholds are compared strictly; control is off only when both
// errors fall below the inner thresholds, or below the outer ones while already off.
module attitude_error_deadband #(
	parameter int CORDIC_STEPS = aed_pkg::CORDIC_STEPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [aed_pkg::CIDX_W-1:0]  cfg_idx,
	input  logic [aed_pkg::THR_W-1:0]   cfg_wdata,
	aed_in_if.sink                      in_item,
	aed_out_if.source                   out_item
);
	import aed_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_NORM_S = 3'd1;
	localparam logic [2:0] ST_CORDIC = 3'd2;
	localparam logic [2:0] ST_NORM_W = 3'd3;
	localparam logic [2:0] ST_DECIDE = 3'd4;

	logic [2:0]  state_q;
	thr_t        outer_att_q, inner_att_q, outer_rate_q, inner_rate_q;
	logic        was_off_q;
	vec3_t       sig_q, omg_q;
	thr_t        att_q;
	norm_t       rate_q;
	logic        norm_start_q, cordic_start_q;
	logic        out_valid_q;
	vec3_t       out_sig_q, out_omg_q;
	logic        out_off_q;

	unit_cmd_t   norm_cmd, cordic_cmd;
	vec3_t       norm_vec;
	logic        norm_done, cordic_done;
	norm_t       norm_root;
	thr_t        cordic_angle;
	logic        in_acc, out_free, below_outer, below_inner, off;

	assign in_acc   = in_item.valid && in_item.ready;
	assign out_free = !out_valid_q || out_item.ready;
	assign in_item.ready = (state_q == ST_IDLE);

	assign norm_cmd.start   = norm_start_q;
	assign cordic_cmd.start = cordic_start_q;
	assign norm_vec = (state_q == ST_NORM_W) ? omg_q : sig_q;

	aed_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (norm_cmd),
		.vec    (norm_vec),
		.done   (norm_done),
		.root   (norm_root)
	);

	aed_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cordic_cmd),
		.n      (norm_root),
		.done   (cordic_done),
		.angle  (cordic_angle)
	);

	// Deadband decision with hysteresis
	always_comb begin
		below_outer = (att_q < outer_att_q) && (rate_q < outer_rate_q);
		below_inner = (att_q < inner_att_q) && (rate_q < inner_rate_q);
		off         = below_outer && (below_inner || was_off_q);
	end

	// Configuration registers; unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_att_q  <= '0;
			inner_att_q  <= '0;
			outer_rate_q <= '0;
			inner_rate_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_OUTER_ATT:  outer_att_q  <= cfg_wdata;
				REG_INNER_ATT:  inner_att_q  <= cfg_wdata;
				REG_OUTER_RATE: outer_rate_q <= cfg_wdata;
				REG_INNER_RATE: inner_rate_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Sequencer and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			was_off_q      <= 1'b1;
			norm_start_q   <= 1'b0;
			cordic_start_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			norm_start_q   <= 1'b0;
			cordic_start_q <= 1'b0;
			if (out_valid_q && out_item.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q      <= ST_NORM_S;
						norm_start_q <= 1'b1;
					end
				end
				ST_NORM_S: begin
					if (norm_done) begin
						state_q        <= ST_CORDIC;
						cordic_start_q <= 1'b1;
					end
				end
				ST_CORDIC: begin
					if (cordic_done) begin
						state_q      <= ST_NORM_W;
						norm_start_q <= 1'b1;
					end
				end
				ST_NORM_W: begin
					if (norm_done)
						state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (out_free) begin
						state_q     <= ST_IDLE;
						was_off_q   <= off;
						out_valid_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the word, the two errors and the result
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sig_q <= '{x: in_item.sigma_x, y: in_item.sigma_y, z: in_item.sigma_z};
			omg_q <= '{x: in_item.omega_x, y: in_item.omega_y, z: in_item.omega_z};
		end
		if (state_q == ST_CORDIC && cordic_done)
			att_q <= cordic_angle;
		if (state_q == ST_NORM_W && norm_done)
			rate_q <= norm_root;
		if (state_q == ST_DECIDE && out_free) begin
			out_sig_q <= off ? '0 : sig_q;
			out_omg_q <= off ? '0 : omg_q;
			out_off_q <= off;
		end
	end

	assign out_item.valid       = out_valid_q;
	assign out_item.out_sigma_x = out_sig_q.x;
	assign out_item.out_sigma_y = out_sig_q.y;
	assign out_item.out_sigma_z = out_sig_q.z;
	assign out_item.out_omega_x = out_omg_q.x;
	assign out_item.out_omega_y = out_omg_q.y;
	assign out_item.out_omega_z = out_omg_q.z;
	assign out_item.control_off = out_off_q;

endmodule

// File: tb/attitude_error_deadband_tb.sv
// Self-checking testbench for the attitude error deadband with hysteresis.
`timescale 1ns / 1ps

module attitude_error_deadband_tb;
	import aed_pkg::*;

	localparam int N_STEPS    = CORDIC_STEPS_DEF;
	localparam int TAB_LEN    = 24;
	localparam int LIMIT      = 1000000;
	localparam int RAND_PHASE = 8;
	localparam int PHASE_LEN  = 100;
	localparam int TAIL       = 200;
	localparam int N_DIR      = 21;
	localparam int N_DIR_CFG  = 5;
	localparam int CFG_TOP    = 255;

	localparam comp_t CMAX = 16'sh7FFF;
	localparam comp_t CMIN = 16'sh8000;
	localparam thr_t  TMAX = 16'hFFFF;

	// Six components of one word, sigma first, then omega
	typedef comp_t [0:5] err_vec_t;

	typedef struct packed {
		logic     off;
		err_vec_t c;
	} deadband_res_t;

	typedef struct packed {
		logic [2:0] phase;
		logic       known;
		logic       off_val;
		err_vec_t   v;
	} dir_row_t;

	typedef enum int {MAG_SMALL, MAG_MID, MAG_FULL} mag_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [CIDX_W-1:0] cfg_idx;
	logic [THR_W-1:0]  cfg_wdata;

	aed_in_if  in_ch();
	aed_out_if out_ch();

	// Mirror of the threshold registers and the hysteresis bit
	thr_t outer_att_m, inner_att_m, outer_rate_m, inner_rate_m;
	logic was_off_m;

	deadband_res_t due_gated[$];
	int  err_cnt   = 0;
	int  cycle_cnt = 0;
	bit  src_quiet = 1'b0;
	bit  snk_quiet = 1'b0;
	int  stall_left = 0;

	string fld_name [0:5] = '{"sigma_x", "sigma_y", "sigma_z", "omega_x", "omega_y", "omega_z"};

	// atan(2^-i) with 16 fraction bits
	longint atan_tab [0:TAB_LEN-1] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

	// Threshold sets of the directed part: outer att, inner att, outer rate, inner rate
	thr_t [0:3] dir_thr [0:N_DIR_CFG-1] = '{
		'{16'd0, 16'd0, 16'd0, 16'd0},
		'{TMAX, TMAX, TMAX, TMAX},
		'{16'd4096, 16'd2048, 16'd2048, 16'd1024},
		'{16'd2048, 16'd4096, 16'd1024, 16'd2048},
		'{16'd0, TMAX, TMAX, TMAX}
	};

	// Directed words; rows with known set carry the obvious outcome
	dir_row_t dir_tab [0:N_DIR-1] = '{
		// reset thresholds are zero: nothing is below them, control stays on
		'{3'd0, 1'b1, 1'b0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}},
		'{3'd0, 1'b1, 1'b0, '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}},
		'{3'd0, 1'b1, 1'b0, '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}},
		'{3'd0, 1'b1, 1'b0, '{CMAX, CMIN, 16'sd0, CMIN, CMAX, 16'sd1}},
		// full-scale thresholds: every error is below both pairs
		'{3'd1, 1'b1, 1'b1, '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}},
		'{3'd1, 1'b1, 1'b1, '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}},
		'{3'd1, 1'b1, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}},
		'{3'd1, 1'b1, 1'b1, '{CMAX, 16'sd0, CMIN, 16'sd0, CMAX, -16'sd1}},
		// hysteresis walk: hold off, on, hold on, off, on, zero vector, rate on inner edge
		'{3'd2, 1'b0, 1'b0, '{16'sd1500, 16'sd0, 16'sd0, 16'sd1500, 16'sd0, 16'sd0}},
		'{3'd2, 1'b0, 1'b0, '{16'sd0, -16'sd5000, 16'sd0, 16'sd0, 16'sd0, 16'sd0}},
		'{3'd2, 1'b0, 1'b0, '{16'sd0, 16'sd0, 16'sd1500, 16'sd0, -16'sd1500, 16'sd0}},
		'{3'd2, 1'b0, 1'b0, '{-16'sd500, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd500}},
		'{3'd2, 1'b0, 1'b0, '{16'sd100, 16'sd0, 16'sd0, 16'sd3000, 16'sd0, 16'sd0}},
		'{3'd2, 1'b0, 1'b0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}},
		'{3'd2, 1'b0, 1'b0, '{16'sd0, 16'sd0, 16'sd0, 16'sd1024, 16'sd0, 16'sd0}},
		// inner thresholds above the outer ones
		'{3'd3, 1'b0, 1'b0, '{16'sd500, 16'sd0, 16'sd0, 16'sd500, 16'sd0, 16'sd0}},
		'{3'd3, 1'b0, 1'b0, '{16'sd1500, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}},
		'{3'd3, 1'b0, 1'b0, '{16'sd0, 16'sd0, 16'sd0, 16'sd1500, 16'sd0, 16'sd0}},
		'{3'd3, 1'b0, 1'b0, '{16'sd0, -16'sd500, 16'sd0, 16'sd0, 16'sd0, -16'sd500}},
		// zero outer attitude threshold keeps control on
		'{3'd4, 1'b1, 1'b0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}},
		'{3'd4, 1'b1, 1'b0, '{16'sd100, -16'sd100, 16'sd100, -16'sd100, 16'sd100, -16'sd100}}
	};

	attitude_error_deadband #(
		.CORDIC_STEPS(N_STEPS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_item  (in_ch),
		.out_item (out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bitwise integer square root, floor
	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic longint unsigned vec_norm(comp_t a, comp_t b, comp_t c);
		longint sa, sb, sc;
		sa = a;
		sb = b;
		sc = c;
		return int_sqrt(longint'(sa * sa + sb * sb + sc * sc));
	endfunction

	// 4*atan(n) by vectoring CORDIC on (1.0, n); angle out with 13 fraction bits
	function automatic longint att_angle_q13(longint unsigned nrm);
		longint x, y, z, xs, ys;
		int i;
		x = 64'sd65536;
		y = longint'(nrm) * 4;
		z = 0;
		for (i = 0; i < N_STEPS && i < TAB_LEN; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + atan_tab[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - atan_tab[i];
			end
		end
		// residual swing below zero counts as no angle
		if (z < 0)
			z = 0;
		z = z >>> 1;
		if (z > 65535)
			z = 65535;
		return z;
	endfunction

	// Gate one word through the deadband and advance the hysteresis bit
	function automatic deadband_res_t gate_errors(err_vec_t v);
		longint att, rate;
		logic below_out, below_in, off;
		deadband_res_t r;
		att  = att_angle_q13(vec_norm(v[0], v[1], v[2]));
		rate = longint'(vec_norm(v[3], v[4], v[5]));
		below_out = (att < outer_att_m) && (rate < outer_rate_m);
		below_in  = (att < inner_att_m) && (rate < inner_rate_m);
		off = below_out && (below_in || was_off_m);
		was_off_m = off;
		r.off = off;
		r.c   = off ? '0 : v;
		return r;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		else if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 40);
	endfunction

	function automatic comp_t pick_comp(mag_t m);
		comp_t v;
		if (m == MAG_FULL)
			return comp_t'($urandom);
		if (m == MAG_SMALL)
			v = comp_t'($urandom_range(0, 400));
		else
			v = comp_t'($urandom_range(0, 4000));
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	function automatic mag_t pick_mag();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return MAG_SMALL;
		else if (r < 80)
			return MAG_MID;
		return MAG_FULL;
	endfunction

	function automatic err_vec_t random_errors();
		err_vec_t v;
		mag_t ms, mw;
		int i;
		ms = pick_mag();
		mw = pick_mag();
		for (i = 0; i < 3; i++) begin
			v[i]     = pick_comp(ms);
			v[i + 3] = pick_comp(mw);
		end
		// zero one vector now and then
		if ($urandom_range(0, 19) == 0)
			v[0:2] = '0;
		if ($urandom_range(0, 19) == 0)
			v[3:5] = '0;
		return v;
	endfunction

	function automatic thr_t pick_thr(int typ_max);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		else if (r == 1)
			return TMAX;
		else if (r == 2)
			return thr_t'($urandom);
		return thr_t'($urandom_range(0, typ_max));
	endfunction

	// Write one register; called at a falling edge
	task automatic write_reg(input logic [CIDX_W-1:0] idx, input thr_t d);
		cfg_we    = 1'b1;
		cfg_idx   = idx;
		cfg_wdata = d;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_OUTER_ATT:  outer_att_m  = d;
			REG_INNER_ATT:  inner_att_m  = d;
			REG_OUTER_RATE: outer_rate_m = d;
			REG_INNER_RATE: inner_rate_m = d;
			default: ;
		endcase
	endtask

	// Load all four thresholds, then a write to an unused index that must be dropped
	task automatic load_thresholds(input thr_t o_att, input thr_t i_att,
			input thr_t o_rate, input thr_t i_rate);
		write_reg(REG_OUTER_ATT, o_att);
		write_reg(REG_INNER_ATT, i_att);
		write_reg(REG_OUTER_RATE, o_rate);
		write_reg(REG_INNER_RATE, i_rate);
		write_reg(CIDX_W'($urandom_range(int'(REG_INNER_RATE) + 1, CFG_TOP)),
			thr_t'($urandom));
	endtask

	// Wait until every due result has come back; returns at a falling edge
	task automatic drain();
		while (due_gated.size() != 0)
			@(negedge clk);
	endtask

	// Offer one word and record its outcome once accepted; entered and left at a falling edge
	task automatic send_word(input err_vec_t v, input bit known, input bit known_off);
		int gap;
		deadband_res_t r;
		gap = (src_quiet || $urandom_range(0, 1)) ? 0 : idle_len();
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.sigma_x = v[0];
		in_ch.sigma_y = v[1];
		in_ch.sigma_z = v[2];
		in_ch.omega_x = v[3];
		in_ch.omega_y = v[4];
		in_ch.omega_z = v[5];
		in_ch.valid   = 1'b1;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		r = gate_errors(v);
		if (known) begin
			r.off = known_off;
			r.c   = known_off ? '0 : v;
		end
		due_gated.push_back(r);
		@(negedge clk);
		// drop valid so the accepted word is not offered again
		in_ch.valid = 1'b0;
	endtask

	// Main stimulus
	initial begin
		int i, p, k;
		logic [2:0] cur_phase;
		thr_t ta, tb, tc, td, tmp;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_idx       = '0;
		cfg_wdata     = '0;
		in_ch.valid   = 1'b0;
		in_ch.sigma_x = '0;
		in_ch.sigma_y = '0;
		in_ch.sigma_z = '0;
		in_ch.omega_x = '0;
		in_ch.omega_y = '0;
		in_ch.omega_z = '0;
		outer_att_m   = '0;
		inner_att_m   = '0;
		outer_rate_m  = '0;
		inner_rate_m  = '0;
		was_off_m     = 1'b1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed words, reloading thresholds whenever the phase moves on
		cur_phase = '0;
		for (i = 0; i < N_DIR; i++) begin
			if (dir_tab[i].phase != cur_phase) begin
				drain();
				cur_phase = dir_tab[i].phase;
				load_thresholds(dir_thr[cur_phase][0], dir_thr[cur_phase][1],
					dir_thr[cur_phase][2], dir_thr[cur_phase][3]);
			end
			send_word(dir_tab[i].v, dir_tab[i].known, dir_tab[i].off_val);
		end

		// random phases, each with fresh thresholds and its own idling pattern
		for (p = 0; p < RAND_PHASE; p++) begin
			drain();
			ta = pick_thr(12000);
			tb = pick_thr(12000);
			tc = pick_thr(6000);
			td = pick_thr(6000);
			// keep inner below outer most of the time
			if ($urandom_range(0, 4) != 0) begin
				if (tb > ta) begin
					tmp = ta;
					ta  = tb;
					tb  = tmp;
				end
				if (td > tc) begin
					tmp = tc;
					tc  = td;
					td  = tmp;
				end
			end
			load_thresholds(ta, tb, tc, td);
			src_quiet = ($urandom_range(0, 3) == 0);
			snk_quiet = ($urandom_range(0, 3) == 0);
			for (k = 0; k < PHASE_LEN; k++)
				send_word(random_errors(), 1'b0, 1'b0);
		end

		in_ch.valid = 1'b0;
		drain();
		repeat (TAIL) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Result side: raise ready, holding it low for random stalls
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ch.ready = 1'b0;
				stall_left--;
			end else begin
				out_ch.ready = 1'b1;
				if (!snk_quiet && $urandom_range(0, 3) == 0)
					stall_left = idle_len();
			end
		end
	end

	// Compare each accepted result word with the oldest one due
	always @(posedge clk) begin
		deadband_res_t got, want;
		int f;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			got.c[0] = out_ch.out_sigma_x;
			got.c[1] = out_ch.out_sigma_y;
			got.c[2] = out_ch.out_sigma_z;
			got.c[3] = out_ch.out_omega_x;
			got.c[4] = out_ch.out_omega_y;
			got.c[5] = out_ch.out_omega_z;
			got.off  = out_ch.control_off;
			if (due_gated.size() == 0) begin
				$display("%0t: result word with none due, control_off %0b", $time, got.off);
				err_cnt++;
			end else begin
				want = due_gated.pop_front();
				for (f = 0; f < 6; f++) begin
					if (got.c[f] !== want.c[f]) begin
						$display("%0t: out_%s expected %0d got %0d", $time, fld_name[f],
							want.c[f], got.c[f]);
						err_cnt++;
					end
				end
				if (got.off !== want.off) begin
					$display("%0t: control_off expected %0b got %0b", $time, want.off,
						got.off);
					err_cnt++;
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule
